// ----- rtl/core/rrwl_pkg.sv -----
`default_nettype none

package rrwl_pkg;

  // Default sizing of the lock.
  localparam int THREADS_DEF    = 16;
  localparam int COUNT_BITS_DEF = 16;

  // Fixed field widths of the request and response channels.
  localparam int KIND_W = 3;
  localparam int TID_W  = 4;
  localparam int AMT_W  = 16;
  localparam int CNT_W  = 16;

  // Operation codes carried in the kind field.
  localparam logic [KIND_W-1:0] KIND_WR_ACQ = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WR_REL = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RD_ACQ = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RD_REL = 3'd3;
  localparam logic [KIND_W-1:0] KIND_WR_TRY = 3'd4;
  localparam logic [KIND_W-1:0] KIND_RD_TRY = 3'd5;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_REFUSED  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_ILLEGAL  = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } ctl_state_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TID_W-1:0]  thread_id;
    logic [AMT_W-1:0]  write_amount;
    logic              queued_predecessor;
    logic              head_waiter_is_writer;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic              fully_free;
    logic [CNT_W-1:0]  read_count;
    logic [CNT_W-1:0]  write_count;
    logic              owner_valid;
    logic [TID_W-1:0]  owner_id;
    logic [CNT_W-1:0]  own_read_holds;
    logic [CNT_W-1:0]  own_write_holds;
  } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/rrwl_if.sv -----
`default_nettype none

// Request channel: one lock operation per request.
interface rrwl_req_if import rrwl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TID_W-1:0]  thread_id;
  logic [AMT_W-1:0]  write_amount;
  logic              queued_predecessor;
  logic              head_waiter_is_writer;

  modport source (
    output valid, kind, thread_id, write_amount, queued_predecessor,
           head_waiter_is_writer,
    input  ready
  );
  modport sink (
    input  valid, kind, thread_id, write_amount, queued_predecessor,
           head_waiter_is_writer,
    output ready
  );
endinterface

// Response channel: outcome and lock state after the request.
interface rrwl_rsp_if import rrwl_pkg::*; ();
  logic             valid;
  logic             ready;
  status_t          status;
  logic             fully_free;
  logic [CNT_W-1:0] read_count;
  logic [CNT_W-1:0] write_count;
  logic             owner_valid;
  logic [TID_W-1:0] owner_id;
  logic [CNT_W-1:0] own_read_holds;
  logic [CNT_W-1:0] own_write_holds;

  modport source (
    output valid, status, fully_free, read_count, write_count, owner_valid,
           owner_id, own_read_holds, own_write_holds,
    input  ready
  );
  modport sink (
    input  valid, status, fully_free, read_count, write_count, owner_valid,
           owner_id, own_read_holds, own_write_holds,
    output ready
  );
endinterface

// Configuration write channel for the fairness register.
interface rrwl_cfg_if import rrwl_pkg::*; ();
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rrwl_ram.sv -----
`default_nettype none

module rrwl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rrwl_exec.sv -----
`default_nettype none

module rrwl_exec import rrwl_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire req_t                  req,
  input  wire logic [TID_W-1:0]      tid,
  input  wire logic                  fair_mode,
  input  wire logic [COUNT_BITS-1:0] write_holds,
  input  wire logic [COUNT_BITS-1:0] total_read,
  input  wire logic                  owner_present,
  input  wire logic [TID_W-1:0]      owner_thread,
  input  wire logic [COUNT_BITS-1:0] own_read,
  output      logic [COUNT_BITS-1:0] write_holds_next,
  output      logic [COUNT_BITS-1:0] total_read_next,
  output      logic                  owner_present_next,
  output      logic [TID_W-1:0]      owner_thread_next,
  output      logic [COUNT_BITS-1:0] own_read_next,
  output      logic                  tbl_we,
  output      rsp_t                  rsp
);

  localparam int XW = AMT_W + 1;
  localparam logic [COUNT_BITS-1:0] MAX_HOLDS = {COUNT_BITS{1'b1}};

  logic [XW-1:0] max_x;
  logic [XW-1:0] wh_x;
  logic [XW-1:0] amt_x;
  logic [XW-1:0] sum_x;
  logic          is_owner;
  logic          wr_acq;
  logic          rd_acq;
  logic          wr_policy;
  logic          rd_policy;

  assign max_x    = XW'(MAX_HOLDS);
  assign wh_x     = XW'(write_holds);
  assign is_owner = owner_present && (owner_thread == tid);
  assign wr_acq   = (req.kind == KIND_WR_ACQ) || (req.kind == KIND_WR_TRY);
  assign rd_acq   = (req.kind == KIND_RD_ACQ) || (req.kind == KIND_RD_TRY);

  // The barging try takes one hold and ignores the queue.
  always_comb begin
    if (req.kind == KIND_WR_TRY) begin
      amt_x = XW'(1);
    end else begin
      amt_x = XW'(req.write_amount);
    end
  end

  assign sum_x = wh_x + amt_x;

  // Queue policy for blocking acquires: fair mode yields to any predecessor,
  // nonfair readers yield only to a writer at the head of the queue.
  assign wr_policy = (req.kind == KIND_WR_ACQ) && fair_mode && req.queued_predecessor;
  assign rd_policy = (req.kind == KIND_RD_ACQ) &&
                     (fair_mode ? req.queued_predecessor : req.head_waiter_is_writer);

  // Operation decode and state update.
  always_comb begin
    write_holds_next   = write_holds;
    total_read_next    = total_read;
    owner_present_next = owner_present;
    owner_thread_next  = owner_thread;
    own_read_next      = own_read;
    tbl_we             = 1'b0;
    rsp.status         = ST_REFUSED;
    rsp.fully_free     = 1'b0;

    if (wr_acq) begin
      if ((write_holds != '0) || (total_read != '0)) begin
        if ((write_holds == '0) || !is_owner) begin
          rsp.status = ST_REFUSED;
        end else if (sum_x > max_x) begin
          rsp.status = ST_OVERFLOW;
        end else begin
          write_holds_next = COUNT_BITS'(sum_x);
          rsp.status       = ST_DONE;
        end
      end else if (wr_policy) begin
        rsp.status = ST_REFUSED;
      end else if (amt_x > max_x) begin
        rsp.status = ST_OVERFLOW;
      end else begin
        if (amt_x != '0) begin
          write_holds_next   = COUNT_BITS'(amt_x);
          owner_present_next = 1'b1;
          owner_thread_next  = tid;
        end
        rsp.status = ST_DONE;
      end
    end else if (rd_acq) begin
      if ((write_holds != '0) && !is_owner) begin
        rsp.status = ST_REFUSED;
      end else if (rd_policy && (write_holds == '0) && (own_read == '0)) begin
        rsp.status = ST_REFUSED;
      end else if (total_read == MAX_HOLDS) begin
        rsp.status = ST_OVERFLOW;
      end else begin
        total_read_next = total_read + 1'b1;
        own_read_next   = own_read + 1'b1;
        tbl_we          = 1'b1;
        rsp.status      = ST_DONE;
      end
    end else if (req.kind == KIND_WR_REL) begin
      if (!is_owner || (amt_x > wh_x)) begin
        rsp.status = ST_ILLEGAL;
      end else begin
        write_holds_next = COUNT_BITS'(wh_x - amt_x);
        if (wh_x == amt_x) begin
          owner_present_next = 1'b0;
          owner_thread_next  = '0;
          rsp.fully_free     = 1'b1;
        end
        rsp.status = ST_DONE;
      end
    end else if (req.kind == KIND_RD_REL) begin
      if ((own_read == '0) || (total_read == '0)) begin
        rsp.status = ST_ILLEGAL;
      end else begin
        total_read_next = total_read - 1'b1;
        own_read_next   = own_read - 1'b1;
        tbl_we          = 1'b1;
        rsp.fully_free  = (total_read_next == '0) && (write_holds == '0);
        rsp.status      = ST_DONE;
      end
    end

    // Lock state as seen after the request.
    rsp.read_count      = CNT_W'(total_read_next);
    rsp.write_count     = CNT_W'(write_holds_next);
    rsp.owner_valid     = owner_present_next;
    rsp.owner_id        = owner_present_next ? owner_thread_next : '0;
    rsp.own_read_holds  = CNT_W'(own_read_next);
    if (owner_present_next && (owner_thread_next == tid)) begin
      rsp.own_write_holds = CNT_W'(write_holds_next);
    end else begin
      rsp.own_write_holds = '0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/reentrant_read_write_lock.sv -----
// A request is captured in the request register as its per-thread read-hold
// table entry is read; its result then enters the output register, held back
// only while the previous result still waits there. A new request is taken
// only after the previous one commits, set by the read and later write-back of
// that table entry. Reset: counts, owner and the fairness register clear
// synchronously; every table entry reads as zero until it is first written.
`default_nettype none

module reentrant_read_write_lock import rrwl_pkg::*; #(
  parameter int THREADS    = THREADS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  rrwl_req_if.sink   req,
  rrwl_rsp_if.source rsp,
  rrwl_cfg_if.sink   cfg
);

  localparam int IDX_W = $clog2(THREADS);

  ctl_state_t            state;
  ctl_state_t            state_next;
  logic                  fair_mode;
  logic [COUNT_BITS-1:0] write_holds;
  logic [COUNT_BITS-1:0] total_read;
  logic                  owner_present;
  logic [TID_W-1:0]      owner_thread;
  logic [THREADS-1:0]    ent_valid;
  req_t                  req_q;
  logic [TID_W-1:0]      tid_q;
  logic [IDX_W-1:0]      idx_q;
  logic                  rsp_valid;
  rsp_t                  rsp_q;

  logic                  req_ready;
  logic                  accept;
  logic                  commit;
  logic [TID_W-1:0]      tid_mod;
  logic [IDX_W-1:0]      rd_idx;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic [COUNT_BITS-1:0] own_read;

  logic [COUNT_BITS-1:0] write_holds_next;
  logic [COUNT_BITS-1:0] total_read_next;
  logic                  owner_present_next;
  logic [TID_W-1:0]      owner_thread_next;
  logic [COUNT_BITS-1:0] own_read_next;
  logic                  tbl_we;
  rsp_t                  rsp_calc;

  // Thread id reduced into the table range by conditional subtraction.
  always_comb begin
    int t;
    t = int'(req.thread_id);
    for (int k = TID_W - 1; k >= 0; k--) begin
      if (t >= (THREADS << k)) begin
        t = t - (THREADS << k);
      end
    end
    tid_mod = TID_W'(t);
  end

  assign rd_idx = IDX_W'(tid_mod);
  assign accept = req.valid && req_ready;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!rsp_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    req_ready = 1'b0;
    commit    = 1'b0;
    case (state)
      S_IDLE:  req_ready = 1'b1;
      S_EXEC:  commit    = !rsp_valid || rsp.ready;
      default: begin
        req_ready = 1'b0;
        commit    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Fairness register; always ready to take a write.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fair_mode <= 1'b0;
    end else if (cfg.valid) begin
      fair_mode <= cfg.data;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q.kind                  <= req.kind;
      req_q.thread_id             <= req.thread_id;
      req_q.write_amount          <= req.write_amount;
      req_q.queued_predecessor    <= req.queued_predecessor;
      req_q.head_waiter_is_writer <= req.head_waiter_is_writer;
      tid_q                       <= tid_mod;
      idx_q                       <= rd_idx;
    end
  end

  // Per-thread read-hold table.
  rrwl_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (THREADS)
  ) u_tbl (
    .clk   (clk),
    .we    (commit && tbl_we),
    .waddr (idx_q),
    .wdata (own_read_next),
    .re    (accept),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  assign own_read = ent_valid[idx_q] ? ram_rdata : '0;

  rrwl_exec #(
    .COUNT_BITS (COUNT_BITS)
  ) u_exec (
    .req                (req_q),
    .tid                (tid_q),
    .fair_mode          (fair_mode),
    .write_holds        (write_holds),
    .total_read         (total_read),
    .owner_present      (owner_present),
    .owner_thread       (owner_thread),
    .own_read           (own_read),
    .write_holds_next   (write_holds_next),
    .total_read_next    (total_read_next),
    .owner_present_next (owner_present_next),
    .owner_thread_next  (owner_thread_next),
    .own_read_next      (own_read_next),
    .tbl_we             (tbl_we),
    .rsp                (rsp_calc)
  );

  // Lock state and table valid bits, updated on commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_holds   <= '0;
      total_read    <= '0;
      owner_present <= 1'b0;
      owner_thread  <= '0;
      ent_valid     <= '0;
    end else if (commit) begin
      write_holds   <= write_holds_next;
      total_read    <= total_read_next;
      owner_present <= owner_present_next;
      owner_thread  <= owner_thread_next;
      if (tbl_we) begin
        ent_valid[idx_q] <= 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp_q <= rsp_calc;
    end
  end

  assign req.ready           = req_ready;
  assign rsp.valid           = rsp_valid;
  assign rsp.status          = rsp_q.status;
  assign rsp.fully_free      = rsp_q.fully_free;
  assign rsp.read_count      = rsp_q.read_count;
  assign rsp.write_count     = rsp_q.write_count;
  assign rsp.owner_valid     = rsp_q.owner_valid;
  assign rsp.owner_id        = rsp_q.owner_id;
  assign rsp.own_read_holds  = rsp_q.own_read_holds;
  assign rsp.own_write_holds = rsp_q.own_write_holds;

endmodule

`default_nettype wire
